// ----- rtl/htf_pkg.sv -----
// Shared constants, the MAC control struct and the coefficient builder.
// Depends on nothing; imported by htf_mac and the top level of the Hilbert FIR.
package htf_pkg;

  localparam int TAPS_DEF        = 256;
  localparam int SAMPLE_BITS_DEF = 24;
  localparam int COEFF_BITS_DEF  = 18;
  localparam int HALF_KNOWN      = 128;
  localparam longint unsigned GAIN_E10 = 64'd15704839670;

  // Positive half of the prototype scaled by 1e10, outermost tap first.
  localparam longint unsigned PROTO_E10 [HALF_KNOWN] = '{
    64'd3138613, 64'd3174376, 64'd3221740, 64'd3280972, 64'd3352340, 64'd3436114,
    64'd3532566, 64'd3641970, 64'd3764603, 64'd3900744, 64'd4050673, 64'd4214676,
    64'd4393040, 64'd4586054, 64'd4794011, 64'd5017209, 64'd5255947, 64'd5510531,
    64'd5781267, 64'd6068469, 64'd6372454, 64'd6693544, 64'd7032067, 64'd7388356,
    64'd7762750, 64'd8155595, 64'd8567243, 64'd8998053, 64'd9448395, 64'd9918643,
    64'd10409181, 64'd10920405, 64'd11452719, 64'd12006537, 64'd12582286,
    64'd13180405, 64'd13801346, 64'd14445576, 64'd15113575, 64'd15805840,
    64'd16522886, 64'd17265245, 64'd18033470, 64'd18828134, 64'd19649832,
    64'd20499184, 64'd21376834, 64'd22283457, 64'd23219754, 64'd24186459,
    64'd25184340, 64'd26214200, 64'd27276884, 64'd28373275, 64'd29504304,
    64'd30670949, 64'd31874241, 64'd33115266, 64'd34395171, 64'd35715167,
    64'd37076536, 64'd38480636, 64'd39928907, 64'd41422875, 64'd42964166,
    64'd44554506, 64'd46195735, 64'd47889815, 64'd49638842, 64'd51445053,
    64'd53310847, 64'd55238792, 64'd57231643, 64'd59292361, 64'd61424131,
    64'd63630386, 64'd65914829, 64'd68281459, 64'd70734605, 64'd73278960,
    64'd75919615, 64'd78662107, 64'd81512469, 64'd84477282, 64'd87563740,
    64'd90779724, 64'd94133886, 64'd97635740, 64'd101295776, 64'd105125586,
    64'd109138011, 64'd113347310, 64'd117769368, 64'd122421921, 64'd127324845,
    64'd132500473, 64'd137973997, 64'd143773929, 64'd149932668, 64'd156487183,
    64'd163479841, 64'd170959429, 64'd178982414, 64'd187614506, 64'd196932631,
    64'd207027420, 64'd218006399, 64'd229998108, 64'd243157494, 64'd257673042,
    64'd273776363, 64'd291755264, 64'd311971870, 64'd334888257, 64'd361103470,
    64'd391408311, 64'd426868713, 64'd468956751, 64'd519764409, 64'd582368230,
    64'd661485683, 64'd764737425, 64'd905286557, 64'd1107996896, 64'd1426148288,
    64'd1998268664, 64'd3332294323, 64'd9999653629
  };

  typedef struct packed {
    logic start;  // clear the accumulator
    logic issue;  // a tap read was issued this cycle
    logic last;   // final tap of the walk
    logic live;   // tap holds a written sample (else reads as zero)
  } htf_mac_ctrl_t;

  // round(c * 2^(cb-1) / GAIN), ties away from zero, by restoring division
  function automatic longint htf_quant(longint unsigned c, int cb);
    longint unsigned r;
    longint unsigned q;
    r = c;
    q = 0;
    for (int b = 0; b < cb; b++) begin
      r = r << 1;
      q = q << 1;
      if (r >= GAIN_E10) begin
        r = r - GAIN_E10;
        q = q | 64'd1;
      end
    end
    return longint'((q + 64'd1) >> 1);
  endfunction

  // Signed ROM word for tap i of an antisymmetric line of the given length
  function automatic longint htf_coef(int i, int taps, int cb);
    int half;
    int k;
    longint v;
    half = taps / 2;
    v = 0;
    k = (i >= half) ? i - half : half - 1 - i;
    if (k < HALF_KNOWN) v = htf_quant(PROTO_E10[HALF_KNOWN - 1 - k], cb);
    return (i >= half) ? -v : v;
  endfunction

endpackage

// ----- rtl/htf_line_mem.sv -----
// Sample store for both delay lines: one write port, one registered read port.
// Depends on nothing outside this file.
module htf_line_mem #(
  parameter int AW = 9,
  parameter int DW = 24
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/htf_mac.sv -----
// Shared multiply-accumulate unit with round and saturate at the end of a walk.
// Depends on htf_pkg for the control struct.
module htf_mac
  import htf_pkg::*;
#(
  parameter int TAPS        = TAPS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int COEFF_BITS  = COEFF_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  htf_mac_ctrl_t                 ctrl,
  input  logic signed [SAMPLE_BITS-1:0] data,
  input  logic signed [COEFF_BITS-1:0]  coef,
  output logic                          res_valid,
  output logic signed [SAMPLE_BITS-1:0] result
);

  localparam int PROD_W = SAMPLE_BITS + COEFF_BITS;
  localparam int ACC_W  = PROD_W + $clog2(TAPS) + 1;
  localparam logic signed [ACC_W-1:0] HALF_LSB = ACC_W'(64'd1 << (COEFF_BITS - 2));
  localparam logic signed [ACC_W-1:0] MAXV = ACC_W'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
  localparam logic signed [ACC_W-1:0] MINV = -MAXV - ACC_W'(1);

  logic                     s1_issue, s1_last, s1_live;
  logic                     s2_issue, s2_last;
  logic                     s3_last, s4_last;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  rnd;
  logic signed [ACC_W-1:0]  shifted;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_issue  <= 1'b0;
      s1_last   <= 1'b0;
      s1_live   <= 1'b0;
      s2_issue  <= 1'b0;
      s2_last   <= 1'b0;
      s3_last   <= 1'b0;
      s4_last   <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      s1_issue  <= ctrl.issue;
      s1_last   <= ctrl.issue & ctrl.last;
      s1_live   <= ctrl.live;
      s2_issue  <= s1_issue;
      s2_last   <= s1_last;
      s3_last   <= s2_last;
      s4_last   <= s3_last;
      res_valid <= s4_last;
    end
  end

  // data and coef arrive in the cycle after the issue, aligned with s1
  always_ff @(posedge clk) begin
    prod <= s1_live ? PROD_W'(data * coef) : '0;
    if (ctrl.start) begin
      acc <= '0;
    end else if (s2_issue) begin
      acc <= acc + {{(ACC_W - PROD_W){prod[PROD_W-1]}}, prod};
    end
    if (s3_last) rnd <= acc + HALF_LSB;
    if (s4_last) begin
      if (shifted > MAXV) begin
        result <= MAXV[SAMPLE_BITS-1:0];
      end else if (shifted < MINV) begin
        result <= MINV[SAMPLE_BITS-1:0];
      end else begin
        result <= shifted[SAMPLE_BITS-1:0];
      end
    end
  end

  assign shifted = rnd >>> (COEFF_BITS - 1);

endmodule

// ----- rtl/hilbert_transform_fir_unit.sv -----
// Top level of the Hilbert transformer FIR: sequencer, delay-line bookkeeping,
// coefficient ROM and output register. Depends on htf_pkg, htf_line_mem, htf_mac.

// One sample in, one 90-degree-shifted sample out. Each accepted word is pushed
// into one of two delay lines of TAPS samples (the lines alternate, line a first),
// and the result is the dot product of the other line with an antisymmetric
// coefficient ROM, rounded to Q1.(SAMPLE_BITS-1) and saturated. An input word
// therefore shows up in the output only on the following step. A single
// multiplier walks all taps, one per cycle, reading the shared sample memory
// through its one read port; the sum then passes the MAC's round and saturate
// registers into the output register, and s_tready is low from acceptance
// until then. The output register lets the next word be taken while the
// previous result still waits. Reset needs no clearing pass: a per-line fill
// count makes never-written taps read as zero.
module hilbert_transform_fir_unit
  import htf_pkg::*;
#(
  parameter int TAPS        = TAPS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int COEFF_BITS  = COEFF_BITS_DEF,
  localparam int TDW        = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  logic [TDW-1:0] s_tdata,   // [SAMPLE_BITS-1:0] sample_in, rest zero
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [TDW-1:0] m_tdata    // [SAMPLE_BITS-1:0] sample_out, rest zero
);

  localparam int PW = $clog2(TAPS);
  localparam int FW = $clog2(TAPS + 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_RUN   = 4'b0010,
    S_DRAIN = 4'b0100,
    S_OUT   = 4'b1000
  } state_t;

  state_t        state;
  logic          sel;          // line written by the next word
  logic [PW-1:0] ptr  [2];     // next slot to write in each line, its oldest once full
  logic [FW-1:0] fill [2];     // written slots, saturating at TAPS
  logic          rd_line;
  logic [PW-1:0] rd_addr;
  logic [FW-1:0] rd_fill;
  logic [PW-1:0] cnt;
  logic          accept;
  logic          out_free;
  logic          out_load;

  logic signed [COEFF_BITS-1:0]  rom [TAPS];
  logic signed [COEFF_BITS-1:0]  coef_q;
  logic [SAMPLE_BITS-1:0]        mem_q;
  htf_mac_ctrl_t                 ctrl;
  logic                          res_valid;
  logic signed [SAMPLE_BITS-1:0] result;

  // ROM words are fixed at elaboration
  for (genvar g = 0; g < TAPS; g++) begin : g_rom
    assign rom[g] = COEFF_BITS'(htf_coef(g, TAPS, COEFF_BITS));
  end

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid & s_tready;
  assign out_free = ~m_tvalid | m_tready;
  // load the output register once the sum is done and the slot is free
  assign out_load = ((state == S_DRAIN) && res_valid && out_free) ||
                    ((state == S_OUT) && out_free);

  // issue one tap per cycle while walking; a tap is live once the line has
  // received enough words to reach it
  always_comb begin
    ctrl.start = accept;
    ctrl.issue = (state == S_RUN);
    ctrl.last  = (cnt == PW'(TAPS - 1));
    ctrl.live  = ((FW + 1)'(cnt) + (FW + 1)'(rd_fill)) >= (FW + 1)'(TAPS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      sel      <= 1'b0;
      ptr[0]   <= '0;
      ptr[1]   <= '0;
      fill[0]  <= '0;
      fill[1]  <= '0;
      m_tvalid <= 1'b0;
      cnt      <= '0;
    end else begin
      if (out_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            // push into the current line, then walk the other one
            ptr[sel] <= (ptr[sel] == PW'(TAPS - 1)) ? '0 : ptr[sel] + PW'(1);
            if (fill[sel] != FW'(TAPS)) fill[sel] <= fill[sel] + FW'(1);
            sel     <= ~sel;
            rd_line <= ~sel;
            rd_addr <= ptr[~sel];
            rd_fill <= fill[~sel];
            cnt     <= '0;
            state   <= S_RUN;
          end
        end
        S_RUN: begin
          cnt     <= cnt + PW'(1);
          rd_addr <= (rd_addr == PW'(TAPS - 1)) ? '0 : rd_addr + PW'(1);
          if (ctrl.last) state <= S_DRAIN;
        end
        S_DRAIN: begin
          if (res_valid) begin
            if (out_free) begin
              state <= S_IDLE;
            end else begin
              state <= S_OUT;
            end
          end
        end
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output payload: load alongside m_tvalid
  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= TDW'({1'b0, result} & {1'b0, {SAMPLE_BITS{1'b1}}});
    end
  end

  // coefficient read aligned with the memory read
  always_ff @(posedge clk) begin
    coef_q <= rom[cnt];
  end

  htf_line_mem #(
    .AW(PW + 1),
    .DW(SAMPLE_BITS)
  ) u_mem (
    .clk  (clk),
    .we   (accept),
    .waddr({sel, ptr[sel]}),
    .wdata(s_tdata[SAMPLE_BITS-1:0]),
    .raddr({rd_line, rd_addr}),
    .rdata(mem_q)
  );

  htf_mac #(
    .TAPS       (TAPS),
    .SAMPLE_BITS(SAMPLE_BITS),
    .COEFF_BITS (COEFF_BITS)
  ) u_mac (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .data     (signed'(mem_q)),
    .coef     (coef_q),
    .res_valid(res_valid),
    .result   (result)
  );

  // a finished sum appears only while the sequencer waits for it
  a_res_in_drain: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> state == S_DRAIN)
    else $error("MAC result outside drain");

  // an accepted word starts a tap walk on the next cycle
  a_accept_runs: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_RUN && cnt == '0)
    else $error("walk did not start after accept");

  // the line being walked is never the one just written
  a_line_alt: assert property (@(posedge clk) disable iff (rst)
    accept |=> rd_line != $past(sel))
    else $error("walk line equals write line");

endmodule
